// ===== rtl/dtti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_pkg
// Types and character constants shared by the decimal text converter.
// ----------------------------------------------------------------------------
package dtti_pkg;

  localparam int unsigned VALUE_W = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [VALUE_W-1:0] S32_POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] INT32_NEG_MAG = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_SPACES = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2,
    PH_FAIL   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       no_char;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
  } out_word_t;

  typedef struct packed {
    logic signed_mode;
  } cfg_word_t;

  typedef struct packed {
    phase_t             phase;
    logic               is_negative;
    logic [VALUE_W-1:0] accumulator;
    logic               overflowed;
    logic               seen_any;
  } parse_st_t;

  localparam parse_st_t PARSE_CLEAR = '{
    phase:       PH_SPACES,
    is_negative: 1'b0,
    accumulator: '0,
    overflowed:  1'b0,
    seen_any:    1'b0
  };

endpackage

// ===== rtl/dtti_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_chan_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface dtti_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dtti_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_step
// Parse state update for one character: phase transitions and value*10+digit.
// ----------------------------------------------------------------------------
module dtti_step (
  input  dtti_pkg::parse_st_t cur,
  input  logic [7:0]          char_code,
  input  logic                no_char,
  output dtti_pkg::parse_st_t nxt
);
  import dtti_pkg::*;

  logic        is_digit;
  logic        is_stopper;
  logic        is_sign;
  logic [3:0]  dval;
  logic [35:0] mac;

  assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_stopper = (char_code == CH_COMMA) || (char_code == CH_DOT) ||
                      (char_code == CH_SPACE);
  assign is_sign    = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  // low nibble of '0'..'9' is the digit itself
  assign dval       = char_code[3:0];

  // acc*10 as (acc<<3) + (acc<<1), four guard bits catch the carry out
  assign mac = {1'b0, cur.accumulator, 3'b000} + {3'b000, cur.accumulator, 1'b0} +
               {32'd0, dval};

  always_comb begin
    nxt = cur;
    if (!no_char) begin
      nxt.seen_any = 1'b1;
      case (cur.phase)
        PH_SPACES: begin
          if (char_code == CH_SPACE) begin
            nxt.phase = PH_SPACES;
          end else if (is_sign) begin
            nxt.is_negative = (char_code == CH_MINUS);
            nxt.phase       = PH_DIGITS;
          end else if (is_digit) begin
            nxt.accumulator = mac[31:0];
            nxt.overflowed  = cur.overflowed | (|mac[35:32]);
            nxt.phase       = PH_DIGITS;
          end else if (is_stopper) begin
            nxt.phase = PH_STOP;
          end else begin
            nxt.phase = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            nxt.accumulator = mac[31:0];
            nxt.overflowed  = cur.overflowed | (|mac[35:32]);
          end else if (is_stopper) begin
            nxt.phase = PH_STOP;
          end else begin
            nxt.phase = PH_FAIL;
          end
        end
        default: begin
          nxt.phase = cur.phase;  // stopped or failed: rest of string ignored
        end
      endcase
    end
  end

endmodule

// ===== rtl/dtti_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtti_finish
// Forms the result word from the final parse state: range check and sign.
// ----------------------------------------------------------------------------
module dtti_finish (
  input  dtti_pkg::parse_st_t st,
  input  logic                signed_mode,
  output dtti_pkg::out_word_t res
);
  import dtti_pkg::*;

  logic ok_base;
  logic range_bad;
  logic ok;
  logic [VALUE_W-1:0] mag_neg;

  assign ok_base   = st.seen_any && (st.phase != PH_FAIL) && !st.overflowed;
  assign range_bad = st.is_negative ? (st.accumulator > INT32_NEG_MAG)
                                    : (st.accumulator > S32_POS_MAX);
  assign ok        = ok_base && !(signed_mode && range_bad);
  assign mag_neg   = '0 - st.accumulator;

  always_comb begin
    res.ok    = ok;
    res.value = '0;
    if (ok) begin
      res.value = (signed_mode && st.is_negative) ? mag_neg : st.accumulator;
    end
  end

endmodule

// ===== rtl/decimal_text_to_integer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// ASCII decimal string to 32-bit integer, one character per word.
// ----------------------------------------------------------------------------
// Takes one character word per clock cycle with no gaps between strings; a
// result word comes out for each word marked last, valid once that word has gone
// through the input register, then the finish register that takes the
// updated parse state, then the output register. The per-character step
// is a shift-add multiply by ten plus the digit on the 32-bit accumulator, so
// the parse-state register sets the rate of one character per cycle. Up to
// two finished results wait in the finish and output registers while new
// characters keep flowing in; a stalled output only blocks the input once
// both hold a result and a further last word reaches the parse stage.
// signed_mode may be written only while no string is in flight.
// ----------------------------------------------------------------------------
module decimal_text_to_integer (
  input logic        clk,
  input logic        rst_n,
  dtti_chan_if.sink   in_ch,
  dtti_chan_if.source out_ch,
  dtti_chan_if.sink   cfg_ch
);
  import dtti_pkg::*;

  logic      signed_mode_r;

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;

  parse_st_t st_r, st_nxt;
  parse_st_t st_step;

  logic      fin_valid_r, fin_valid_nxt;
  parse_st_t fin_st_r;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  out_word_t fin_res;

  logic      out_take;
  logic      fin_ready;
  logic      s1_fire;
  logic      in_fire;
  logic      fin_move;
  logic      s1_end;

  assign out_take  = !out_valid_r || out_ch.ready;
  assign fin_ready = !fin_valid_r || out_take;
  assign s1_fire   = s1_valid_r && (!s1_word_r.last || fin_ready);
  assign s1_end    = s1_fire && s1_word_r.last;
  assign fin_move  = fin_valid_r && out_take;

  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  dtti_step u_step (
    .cur       (st_r),
    .char_code (s1_word_r.char_code),
    .no_char   (s1_word_r.no_char),
    .nxt       (st_step)
  );

  dtti_finish u_finish (
    .st          (fin_st_r),
    .signed_mode (signed_mode_r),
    .res         (fin_res)
  );

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
    fin_valid_nxt = s1_end || (fin_valid_r && !out_take);
    out_valid_nxt = fin_move || (out_valid_r && !out_ch.ready);
    st_nxt        = st_r;
    if (s1_fire) begin
      st_nxt = s1_word_r.last ? PARSE_CLEAR : st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      fin_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      st_r          <= PARSE_CLEAR;
    end else begin
      if (cfg_ch.valid) begin
        signed_mode_r <= cfg_ch.data.signed_mode;
      end
      s1_valid_r  <= s1_valid_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_ch.data;
    end
    if (s1_end) begin
      fin_st_r <= st_step;  // state including the last character
    end
    if (fin_move) begin
      out_word_r <= fin_res;
    end
  end

endmodule

// ===== tb/sv/tb_decimal_text_to_integer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_integer
// Self-checking bench for the decimal text to integer converter.
// ----------------------------------------------------------------------------
// The bench feeds text strings one character word at a time. Each accepted
// word goes through a local parser that mirrors the block's rules. A word
// marked last queues one expected result. Each result word is compared with
// the oldest queued result. Directed strings cover the edge cases. Random
// strings follow: mostly well-formed numbers, some of them near the 32-bit
// limits, plus noise bytes, stoppers, trailing junk and empty words. Both
// channels stall at random, and the signed mode is switched between phases.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_integer;
  import dtti_pkg::*;

  logic clk;
  logic rst_n;

  dtti_chan_if #(.T(in_word_t))  in_ch ();
  dtti_chan_if #(.T(out_word_t)) out_ch ();
  dtti_chan_if #(.T(cfg_word_t)) cfg_ch ();

  decimal_text_to_integer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the parse state and the mode register
  phase_t             ph;
  logic               neg;
  logic [VALUE_W-1:0] acc;
  logic               ovf;
  logic               seen;
  logic               mode;

  out_word_t   pending_conv[$];
  out_word_t   oldest_conv;
  logic [7:0]  text_q[$];

  bit in_idle;
  bit out_idle;
  int errors;
  int words_sent;
  int strings_sent;
  int results_seen;
  int ok_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_decimal_text_to_integer: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  function automatic void clear_parse();
    ph   = PH_SPACES;
    neg  = 1'b0;
    acc  = '0;
    ovf  = 1'b0;
    seen = 1'b0;
  endfunction

  function automatic void add_digit(logic [7:0] c);
    longint unsigned nxt;
    nxt = acc;
    nxt = nxt * 10 + (c - CH_ZERO);
    if (nxt > 64'hFFFF_FFFF) ovf = 1'b1;
    acc = nxt[31:0];
    ph  = PH_DIGITS;
  endfunction

  // Parser step for one accepted word; queues the expected result on last.
  function automatic void track_text_word(in_word_t w);
    logic      digit;
    logic      stopper;
    out_word_t res;
    if (!w.no_char) begin
      seen    = 1'b1;
      digit   = (w.char_code >= CH_ZERO) && (w.char_code <= CH_NINE);
      stopper = (w.char_code == CH_COMMA) || (w.char_code == CH_DOT) ||
                (w.char_code == CH_SPACE);
      case (ph)
        PH_SPACES: begin
          if (w.char_code == CH_SPACE) begin
          end else if (w.char_code == CH_PLUS || w.char_code == CH_MINUS) begin
            neg = (w.char_code == CH_MINUS);
            ph  = PH_DIGITS;
          end else if (digit) begin
            add_digit(w.char_code);
          end else if (stopper) begin
            ph = PH_STOP;
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_DIGITS: begin
          if (digit) add_digit(w.char_code);
          else if (stopper) ph = PH_STOP;
          else ph = PH_FAIL;
        end
        default: ;
      endcase
    end
    if (w.last) begin
      res.ok    = seen && (ph != PH_FAIL) && !ovf;
      res.value = acc;
      if (res.ok && mode) begin
        if (neg) begin
          if (acc > INT32_NEG_MAG) res.ok = 1'b0;
          else res.value = 32'd0 - acc;
        end else if (acc > S32_POS_MAX) begin
          res.ok = 1'b0;
        end
      end
      if (!res.ok) res.value = '0;
      pending_conv.push_back(res);
      clear_parse();
    end
  endfunction

  // Sends one word; valid stays high on return so a back-to-back word keeps it up.
  task automatic send_word(logic [7:0] c, bit nc, bit lst);
    int       gap;
    in_word_t w;
    gap = in_idle ? $urandom_range(0, 14) : 0;
    w.char_code = c;
    w.no_char   = nc;
    w.last      = lst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    track_text_word(w);
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Sends text_q as one string; blank_pct is the chance of an empty word before a char.
  task automatic send_text(bit blank_end, int blank_pct);
    int n;
    n = text_q.size();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < blank_pct)
        send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_word(text_q[k], 1'b0, (k == n - 1) && !blank_end);
    end
    if (blank_end || n == 0) send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_conv.size() != 0) @(posedge clk);
  endtask

  // drain the pending results, then leave margin before touching the mode
  task automatic wait_idle();
    drain();
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic m);
    cfg_word_t cw;
    cw.signed_mode = m;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cw;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    mode = m;
  endtask

  // Builds one random string in text_q; returns whether it ends on an empty word.
  function automatic bit build_text();
    longint unsigned v;
    int              sel;
    string           ds;
    bit              blank_end;
    if ($urandom_range(0, 99) < 4) return 1'b1;
    repeat ($urandom_range(0, 3) == 3 ? $urandom_range(1, 3) : 0) text_q.push_back(CH_SPACE);
    case ($urandom_range(0, 3))
      0: text_q.push_back(CH_PLUS);
      1: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = 64'($urandom_range(0, 9));
      1: v = 64'($urandom_range(0, 99999));
      2: v = 64'($urandom);
      3: v = 64'd2147483646 + 64'($urandom_range(0, 2));
      4: v = 64'd4294967294 + 64'($urandom_range(0, 2));
      5: begin
        v = {$urandom, $urandom};
        v = v % 64'd100000000000;
      end
      default: v = 64'($urandom_range(0, 1000000));
    endcase
    if (sel != 6) begin
      ds = $sformatf("%0d", v);
      if ($urandom_range(0, 5) == 0) ds = {"00", ds};
      put_str(ds);
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: text_q.push_back(CH_COMMA);
        1: text_q.push_back(CH_DOT);
        default: text_q.push_back(CH_SPACE);
      endcase
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    // noise byte somewhere in the string
    if ($urandom_range(0, 6) == 0)
      text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
    blank_end = ($urandom_range(0, 7) == 0) || (text_q.size() == 0);
    return blank_end;
  endfunction

  task automatic run_random(int n_words, logic m, bit idle, bit pause_mid);
    int  start;
    bit  blank_end;
    bit  paused;
    wait_idle();
    cfg_write(m);
    in_idle  = idle;
    out_idle = idle;
    start    = words_sent;
    paused   = 1'b0;
    while (words_sent - start < n_words) begin
      if (pause_mid && !paused && (words_sent - start) >= n_words / 2) begin
        // hold the sender until every pending result is out
        drain();
        paused = 1'b1;
      end
      blank_end = build_text();
      send_text(blank_end, 5);
    end
  endtask

  task automatic test_unsigned_directed();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_text(1'b1, 0);                     // empty string
    send_word(CH_SPACE, 1'b0, 1'b0);        // " +9" with an empty word inside
    send_word(8'h00, 1'b1, 1'b0);
    send_word(CH_PLUS, 1'b0, 1'b0);
    send_word(CH_ZERO + 8'd9, 1'b0, 1'b1);
    put_str("-");          send_text(1'b0, 0);
    put_str(" ");          send_text(1'b0, 0);
    put_str("4294967295"); send_text(1'b0, 0);
    put_str("1"); text_q.push_back(8'hFF); send_text(1'b0, 0);
    put_str("7."); text_q.push_back(8'h00); send_text(1'b0, 0);
    put_str("- 5");        send_text(1'b0, 0);
    put_str("+-");         send_text(1'b0, 0);
    put_str("3-");         send_text(1'b0, 0);
    put_str("-7");         send_text(1'b0, 0);
    put_str(",5");         send_text(1'b0, 0);
  endtask

  task automatic test_signed_directed();
    wait_idle();
    cfg_write(1'b1);
    put_str("-2147483648"); send_text(1'b0, 0);
    put_str("-9");          send_text(1'b0, 0);
  endtask

  task automatic test_drain_pause();
    run_random(200, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_back_to_back();
    run_random(120, 1'b1, 1'b0, 1'b0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.data.ok) ok_seen++;
      if (pending_conv.size() == 0) begin
        report_mismatch("unexpected result, value", out_ch.data.value, '0);
      end else begin
        oldest_conv = pending_conv.pop_front();
        if (out_ch.data.ok !== oldest_conv.ok)
          report_mismatch("ok", 32'(out_ch.data.ok), 32'(oldest_conv.ok));
        if (out_ch.data.value !== oldest_conv.value)
          report_mismatch("value", out_ch.data.value, oldest_conv.value);
      end
    end
  end

  // result side: random stall before each word, none when idling is off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    in_idle      = 1'b1;
    out_idle     = 1'b1;
    mode         = 1'b0;
    errors       = 0;
    words_sent   = 0;
    strings_sent = 0;
    results_seen = 0;
    ok_seen      = 0;
    clear_parse();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unsigned_directed();
    test_signed_directed();
    run_random(200, 1'b1, 1'b1, 1'b0);
    test_drain_pause();
    test_back_to_back();
    run_random(50, 1'b0, 1'b1, 1'b0);
    run_random(20, 1'b0, 1'b1, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d strings in %0d words, %0d results (%0d ok)",
             strings_sent, words_sent, results_seen, ok_seen);
    $display("both modes, random stalls, back-to-back words and a drain pause");
    if (errors == 0) begin
      $display("tb_decimal_text_to_integer: PASS");
    end else begin
      $display("tb_decimal_text_to_integer: FAIL");
    end
    $finish;
  end

endmodule
